>>> src/assert_macros.svh
// Assertion macros used by the RTL of the vector table sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clk_i edge outside reset.
`define VVTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vvts assertion failed");

// Next-cycle implication checked at every rising clk_i edge outside reset.
`define VVTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vvts assertion failed");

`endif

>>> src/vvts_pkg.sv
// Types, constants and helpers of the voltage vector table sequencer.
`timescale 1ns / 1ps

package vvts_pkg;

  localparam int unsigned IDX_W = 8;
  localparam int unsigned CNT_W = 8;
  localparam int unsigned VEC_W = 3;
  localparam int unsigned TABLE_DEPTH_DEF = 256;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ZEROS   = 1'd1;

  // Item opcodes.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Vector codes.
  localparam logic [VEC_W-1:0] VEC_ZERO_LO = 3'd0;
  localparam logic [VEC_W-1:0] VEC_ONE     = 3'd1;
  localparam logic [VEC_W-1:0] VEC_THREE   = 3'd3;
  localparam logic [VEC_W-1:0] VEC_FIVE    = 3'd5;
  localparam logic [VEC_W-1:0] VEC_ZERO_HI = 3'd7;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] entry_addr;
    logic [VEC_W-1:0] entry_vector;
    logic [CNT_W-1:0] entry_count;
    logic             enable;
    logic             zero_request;
  } in_t;

  typedef struct packed {
    logic [VEC_W-1:0] vector;
    logic [IDX_W-1:0] entry_index;
    logic [CNT_W-1:0] hold_count;
    logic             zero_inserted;
    logic             no_active_entry;
  } out_t;

  function automatic logic is_zero_vec(input logic [VEC_W-1:0] v);
    return (v == VEC_ZERO_LO) || (v == VEC_ZERO_HI);
  endfunction

  // Zero vector to follow the last one: low-side zero after 0, 1, 3 or 5, high-side zero otherwise.
  function automatic logic [VEC_W-1:0] zero_for(input logic [VEC_W-1:0] v);
    logic lo;
    lo = (v == VEC_ZERO_LO) || (v == VEC_ONE) || (v == VEC_THREE) || (v == VEC_FIVE);
    return lo ? VEC_ZERO_LO : VEC_ZERO_HI;
  endfunction

endpackage

>>> src/voltage_vector_table_sequencer_top.sv
// Top level of the voltage vector table sequencer.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i): one beat is either a
//    control tick or a table entry write. A tick returns the vector to apply,
//    the entry index and hold count after the tick, and two status flags.
//    A write returns one beat too, reporting the state unchanged.
//  - Output channel (out_valid_o / out_stall_i / out_data_o): one beat per
//    input beat, in order. The result sits in an output register, so the next
//    input beat is taken while an earlier result is still stalled.
//  - Config channel (cfg_valid_i / cfg_ready_o): table length and the
//    keep-zeros flag, always ready; write only while the block is idle.
//  Sequencing: a write, a disabled tick or a zero insertion goes from ST_IDLE
//  to ST_FIN; a table walk runs ST_CMP and ST_CHK once per table read (one,
//  plus one per skipped zero vector, at most TABLE_DEPTH), then ST_FIN. Each
//  read costs one hold-count and one vector RAM read, through one port.
//  The sequencer takes no new beat until the current one has been handed
//  to the output register; while out_stall_i holds it, in_stall_o stays high.
//  Reset: index, counter, last vector and config clear; table RAM is not
//  cleared and must be written before it is used.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module voltage_vector_table_sequencer_top #(
  parameter int unsigned TABLE_DEPTH = vvts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  vvts_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output vvts_pkg::out_t                  out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vvts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vvts_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned TW    = $clog2(TABLE_DEPTH);
  localparam int unsigned IW    = vvts_pkg::IDX_W;
  localparam int unsigned CW    = vvts_pkg::CNT_W;
  localparam int unsigned VW    = vvts_pkg::VEC_W;
  localparam int unsigned IXW   = IW + 1;
  localparam int unsigned RAM_W = VW + CW;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a beat
  localparam logic [1:0] ST_CMP  = 2'd1;  // hold count on RAM port
  localparam logic [1:0] ST_CHK  = 2'd2;  // vector on RAM port
  localparam logic [1:0] ST_FIN  = 2'd3;  // hand result to output register

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] last_vec_q, last_vec_d;
  logic [TW-1:0] tries_q, tries_d;
  logic          zins_q, zins_d;
  logic          none_q, none_d;
  logic [IW-1:0] table_len_q;
  logic          nominal_q;
  logic          out_valid_q, out_valid_d;
  vvts_pkg::out_t out_q;

  logic             in_accept;
  logic             out_load;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  logic [RAM_W-1:0] ram_rdata;
  logic [CW-1:0]    rd_count;
  logic [VW-1:0]    rd_vec;

  // Advance datapath, used in ST_CMP.
  logic          cnt_ge;
  logic [IW-1:0] idx_inc;
  logic [IW-1:0] idx_adv;
  logic [CW-1:0] cnt_adv;
  logic [IW-1:0] idx_wrap;

  // RAM address of a hold-count read; indexes past the table read entry 0.
  function automatic logic [AW-1:0] safe_addr(input logic [IW-1:0] idx);
    return (IXW'(idx) < IXW'(TABLE_DEPTH)) ? idx[AW-1:0] : '0;
  endfunction

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  assign ram_we    = in_accept && (in_data_i.op == vvts_pkg::OP_WRITE) &&
                     (IXW'(in_data_i.entry_addr) < IXW'(TABLE_DEPTH));
  assign ram_waddr = in_data_i.entry_addr[AW-1:0];
  assign rd_count  = ram_rdata[CW-1:0];
  assign rd_vec    = ram_rdata[CW +: VW];

  vvts_ram #(
    .WIDTH(RAM_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({in_data_i.entry_vector, in_data_i.entry_count}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    cnt_ge   = (cnt_q >= rd_count);
    idx_inc  = idx_q + IW'(1);
    idx_adv  = cnt_ge ? idx_inc : idx_q;
    cnt_adv  = cnt_ge ? CW'(1) : cnt_q + CW'(1);
    idx_wrap = ((idx_adv >= table_len_q) || (IXW'(idx_adv) >= IXW'(TABLE_DEPTH))) ?
               '0 : idx_adv;
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    last_vec_d  = last_vec_q;
    tries_d     = tries_q;
    zins_d      = zins_q;
    none_d      = none_q;
    out_valid_d = out_valid_q;
    ram_raddr   = safe_addr(idx_q);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          zins_d  = 1'b0;
          none_d  = 1'b0;
          tries_d = '0;
          state_d = ST_FIN;
          if (in_data_i.op == vvts_pkg::OP_WRITE) begin
            state_d = ST_FIN;
          end else if (!in_data_i.enable) begin
            idx_d = '0;
            cnt_d = '0;
          end else if (!nominal_q && in_data_i.zero_request) begin
            last_vec_d = vvts_pkg::zero_for(last_vec_q);
            zins_d     = 1'b1;
          end else begin
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        idx_d     = idx_wrap;
        cnt_d     = cnt_adv;
        ram_raddr = idx_wrap[AW-1:0];
        state_d   = ST_CHK;
      end
      ST_CHK: begin
        last_vec_d = rd_vec;
        state_d    = ST_FIN;
        if (!nominal_q && vvts_pkg::is_zero_vec(rd_vec)) begin
          cnt_d = '0;
          if (tries_q == TW'(TABLE_DEPTH - 1)) begin
            none_d = 1'b1;
          end else begin
            // skip the zero entry and retry from the next one
            idx_d     = idx_inc;
            ram_raddr = safe_addr(idx_inc);
            tries_d   = tries_q + TW'(1);
            state_d   = ST_CMP;
          end
        end
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      last_vec_q  <= '0;
      tries_q     <= '0;
      zins_q      <= 1'b0;
      none_q      <= 1'b0;
      table_len_q <= '0;
      nominal_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      last_vec_q  <= last_vec_d;
      tries_q     <= tries_d;
      zins_q      <= zins_d;
      none_q      <= none_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          vvts_pkg::CFG_TABLE_LENGTH: table_len_q <= cfg_data_i[IW-1:0];
          vvts_pkg::CFG_KEEP_ZEROS:   nominal_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.vector          <= last_vec_q;
      out_q.entry_index     <= idx_q;
      out_q.hold_count      <= cnt_q;
      out_q.zero_inserted   <= zins_q;
      out_q.no_active_entry <= none_q;
    end
  end

  // A failed search always reports a zero vector and never an insertion.
  `VVTS_ASSERT_IMP(a_none_is_zero, out_valid_q && out_q.no_active_entry,
                   vvts_pkg::is_zero_vec(out_q.vector) && !out_q.zero_inserted)
  // Reported entry index always addresses the table.
  `VVTS_ASSERT_IMP(a_index_in_table, out_valid_q,
                   IXW'(out_q.entry_index) < IXW'(TABLE_DEPTH))
  // A vector check always leads to another read or to the result stage.
  `VVTS_ASSERT_NXT(a_chk_next, state_q == ST_CHK,
                   state_q == ST_CMP || state_q == ST_FIN)

endmodule

>>> src/vvts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vvts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> tb/voltage_vector_table_sequencer_top_test.sv
// Self-checking test of the voltage vector table sequencer against a cycle-free predictor.
`timescale 1ns / 1ps

module voltage_vector_table_sequencer_top_test;
  import vvts_pkg::*;

  localparam int unsigned ENTRIES      = 256;
  localparam int unsigned RANDOM_ITEMS = 900;
  // Margin for the worst case: every tick runs a full failed skip search
  // behind long stalls and gaps.
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned END_WAIT     = 5_000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  // Predicts one result beat per accepted input beat and checks the output
  // beats against them in order.
  class seq_scoreboard;
    logic [VEC_W-1:0] vec_mem  [ENTRIES];
    logic [CNT_W-1:0] hold_mem [ENTRIES];
    logic [IDX_W-1:0] cur_idx;
    logic [CNT_W-1:0] cur_cnt;
    logic [VEC_W-1:0] last_vec;
    logic [IDX_W-1:0] seq_len;
    logic             nominal;
    out_t             expected_q [$];
    int unsigned      errors, checked, ticks, writes, inserts, lost_searches;

    function new();
      cur_idx  = '0;
      cur_cnt  = '0;
      last_vec = VEC_ZERO_LO;
      seq_len  = '0;
      nominal  = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] reg_idx, logic [CFG_DATA_W-1:0] value);
      if (reg_idx == CFG_TABLE_LENGTH) seq_len = value;
      else if (reg_idx == CFG_KEEP_ZEROS) nominal = value[0];
    endfunction

    function void note_input(in_t item);
      out_t             want;
      logic [IDX_W-1:0] idx;
      logic [CNT_W-1:0] cnt;
      logic [VEC_W-1:0] v;
      int unsigned      reads;
      logic             searching;
      want = '0;
      if (item.op == OP_WRITE) begin
        vec_mem[item.entry_addr]  = item.entry_vector;
        hold_mem[item.entry_addr] = item.entry_count;
        writes++;
      end else if (!item.enable) begin
        cur_idx = '0;
        cur_cnt = '0;
        ticks++;
      end else if (!nominal && item.zero_request) begin
        // low-side zero after 0, 1, 3, 5; high-side zero otherwise
        if (last_vec == VEC_ZERO_LO || last_vec == VEC_ONE ||
            last_vec == VEC_THREE || last_vec == VEC_FIVE) begin
          last_vec = VEC_ZERO_LO;
        end else begin
          last_vec = VEC_ZERO_HI;
        end
        want.zero_inserted = 1'b1;
        ticks++;
        inserts++;
      end else begin
        idx       = cur_idx;
        cnt       = cur_cnt;
        reads     = 0;
        searching = 1'b1;
        while (searching) begin
          searching = 1'b0;
          if (cnt >= hold_mem[idx]) begin
            cnt = 8'd1;
            idx = idx + 1'b1;
          end else begin
            cnt = cnt + 1'b1;
          end
          if (idx >= seq_len) idx = '0;
          v        = vec_mem[idx];
          last_vec = v;
          reads++;
          // table zero vectors are stepped over, for at most ENTRIES reads
          if (!nominal && (v == VEC_ZERO_LO || v == VEC_ZERO_HI)) begin
            cnt = '0;
            if (reads >= ENTRIES) begin
              want.no_active_entry = 1'b1;
              lost_searches++;
            end else begin
              idx       = idx + 1'b1;
              searching = 1'b1;
            end
          end
        end
        cur_idx = idx;
        cur_cnt = cnt;
        ticks++;
      end
      want.vector      = last_vec;
      want.entry_index = cur_idx;
      want.hold_count  = cur_cnt;
      expected_q.push_back(want);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat %h with nothing expected", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("vector", 8'(want.vector), 8'(got.vector));
      compare_field("entry_index", want.entry_index, got.entry_index);
      compare_field("hold_count", want.hold_count, got.hold_count);
      compare_field("zero_inserted", 8'(want.zero_inserted), 8'(got.zero_inserted));
      compare_field("no_active_entry", 8'(want.no_active_entry), 8'(got.no_active_entry));
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  seq_scoreboard sb = new();
  bit            entry_loaded [ENTRIES];
  int unsigned   burst_left    = 0;
  int unsigned   cycle_count   = 0;
  int unsigned   settings_used = 0;
  stall_mode_e   stall_mode    = STALL_NONE;
  logic [7:0]    stall_clock   = '0;

  voltage_vector_table_sequencer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Output side stalls on its own schedule; a new mode is drawn whenever
  // stall_clock wraps to zero, and the no-stall mode gives stretches of full throughput.
  always @(posedge clk_i) begin
    stall_clock <= stall_clock + 1'b1;
    if (stall_clock == '0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE: begin
        out_stall_i <= 1'b0;
      end
      STALL_LIGHT: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      STALL_HEAVY: begin
        out_stall_i <= ($urandom_range(0, 9) < 7);
      end
      default: begin
        out_stall_i <= (stall_clock[2:0] < 3'd3);
      end
    endcase
  end

  // Sampled before the edge updates land: beats seen here are the ones the
  // block took or gave at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (cfg_valid_i && cfg_ready_o) sb.set_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: no finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Don't-care fields of a beat carry random noise.
  function automatic in_t random_item();
    logic [31:0] raw;
    raw = $urandom;
    return raw[$bits(in_t)-1:0];
  endfunction

  // Mostly short holds so the walk keeps moving; now and then the full range.
  function automatic logic [CNT_W-1:0] rand_hold();
    if ($urandom_range(0, 15) == 0) return CNT_W'($urandom_range(0, 255));
    return CNT_W'($urandom_range(0, 3));
  endfunction

  // One input beat; valid stays up through a burst, then drops for a gap.
  task automatic send_item(input in_t item);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(0, 12);
    end
  endtask

  task automatic load_entry(input logic [IDX_W-1:0] addr, input logic [VEC_W-1:0] vec,
                            input logic [CNT_W-1:0] hold);
    in_t item;
    item              = random_item();
    item.op           = OP_WRITE;
    item.entry_addr   = addr;
    item.entry_vector = vec;
    item.entry_count  = hold;
    entry_loaded[addr] = 1'b1;
    send_item(item);
  endtask

  task automatic tick(input logic en, input logic zreq);
    in_t item;
    item              = random_item();
    item.op           = OP_TICK;
    item.enable       = en;
    item.zero_request = zreq;
    send_item(item);
  endtask

  // Waits until every predicted beat has come back, then a short settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Both registers in back-to-back beats on an idle block.
  task automatic set_mode(input logic [IDX_W-1:0] len, input logic nom);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_TABLE_LENGTH;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_KEEP_ZEROS;
    cfg_data_i  <= {{(CFG_DATA_W-1){1'b0}}, nom};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int unsigned      random_items, phase_len, pick, n;
    logic [IDX_W-1:0] len;
    logic             nom;
    wait (rst_ni);
    @(posedge clk_i);

    // Four-entry table with zero vectors in the middle; entry 4 is loaded
    // because the walk reads the hold count one past a skipped last entry.
    set_mode(8'd4, 1'b0);
    load_entry(8'd0, VEC_ONE, 8'd0);
    load_entry(8'd1, VEC_ZERO_LO, 8'd255);
    load_entry(8'd2, VEC_ZERO_HI, 8'd1);
    load_entry(8'd3, 3'd6, 8'd2);
    load_entry(8'd4, 3'd2, 8'd3);
    load_entry(8'd255, VEC_FIVE, 8'd255);
    tick(1'b1, 1'b0);   // skips both zero vectors
    tick(1'b1, 1'b1);   // inserted zero after 6
    tick(1'b1, 1'b0);
    tick(1'b1, 1'b0);   // wraps at the table length
    tick(1'b1, 1'b1);   // inserted zero after 1
    tick(1'b0, 1'b1);   // disabled wins over the request
    tick(1'b1, 1'b0);

    // Nominal: zero vectors stay, requests are ignored.
    set_mode(8'd4, 1'b1);
    tick(1'b1, 1'b1);
    tick(1'b1, 1'b0);
    tick(1'b1, 1'b0);

    // Zero length: every wrap lands on entry 0.
    set_mode(8'd0, 1'b0);
    tick(1'b1, 1'b0);
    tick(1'b1, 1'b1);

    // Only zero vectors in range: the skip search gives up.
    set_mode(8'd2, 1'b0);
    load_entry(8'd0, VEC_ZERO_LO, 8'd3);
    load_entry(8'd1, VEC_ZERO_HI, 8'd0);
    tick(1'b1, 1'b0);
    load_entry(8'd0, VEC_THREE, 8'd1);
    tick(1'b1, 1'b1);
    tick(1'b1, 1'b0);

    // Random phases; the first one uses the longest table.
    random_items = 0;
    for (int phase = 0; random_items < RANDOM_ITEMS; phase++) begin
      pick = $urandom_range(0, 9);
      if (phase == 0 || pick == 0) len = 8'd255;
      else if (pick == 1) len = 8'd0;
      else if (pick == 2) len = 8'd1;
      else if (pick < 6) len = IDX_W'($urandom_range(2, 8));
      else len = IDX_W'($urandom_range(9, 100));
      nom = ($urandom_range(0, 3) == 0);
      set_mode(len, nom);
      // every entry the walk can touch holds data, one past the end included
      for (int e = 0; e <= len; e++) begin
        if (!entry_loaded[e]) begin
          load_entry(IDX_W'(e), VEC_W'($urandom_range(0, 7)), rand_hold());
          random_items++;
        end
      end
      phase_len = $urandom_range(40, 120);
      for (n = 0; n < phase_len; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          // 8 of 15 rewrites aim inside the active part of the table, if it is not empty
          load_entry((len != 0 && pick < 8) ? IDX_W'($urandom_range(0, len - 1))
                                            : IDX_W'($urandom_range(0, 255)),
                     VEC_W'($urandom_range(0, 7)), rand_hold());
        end else begin
          tick($urandom_range(0, 11) != 0, $urandom_range(0, 4) == 0);
        end
      end
      random_items += phase_len;
    end

    in_valid_i <= 1'b0;
    n = 0;
    do begin
      @(posedge clk_i);
      n++;
    end while (sb.pending() != 0 && n < END_WAIT);
    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time, sb.pending());
      sb.errors += sb.pending();
    end

    $display("Ran %0d ticks (%0d zero insertions, %0d failed skip searches), %0d table writes,",
             sb.ticks, sb.inserts, sb.lost_searches, sb.writes);
    $display("over %0d register settings; %0d result beats checked, %0d mismatches",
             settings_used, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
